@@ hdl/pcpf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpf_pkg
// Types and codes shared by the point cluster proximity filter modules.
// ----------------------------------------------------------------------------
package pcpf_pkg;

  // action codes
  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_TEST   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_KEPT     = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_ACCEPTED = 2'd2;
  localparam logic [1:0] ST_DROPPED  = 2'd3;

  localparam logic [15:0] LIMIT_RESET = 16'd128;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;        // capture request
    logic       cnt_rd;      // read cluster count
    logic       cnt_walk;    // count read address from walk counter
    logic       cnt_wr;      // write cluster count of request's cluster
    logic       cnt_clr;     // written count is zero
    logic       store_wr;    // append point to store
    logic       walk_init;   // restart cluster walk, clear hit
    logic       clu_next;    // advance to next cluster
    logic       pt_start;    // restart point index
    logic       pt_rd;       // issue one store read
    logic       set_status;
    logic [1:0] status;
    logic       res_push;    // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] action;
    logic       cid_ok;
    logic       room;
    logic       cnt_zero;
    logic       pt_last;
    logic       clu_last;
    logic       busy;
    logic       hit;
    logic       out_free;
  } sts_t;

endpackage

@@ hdl/pcpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcpf_ctrl
// Sequencer: decodes a request, runs loads and the store walk of a test.
// ----------------------------------------------------------------------------
module pcpf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pcpf_pkg::sts_t  sts,
  output pcpf_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_LOAD_WR    = 4'd2;
  localparam logic [3:0] S_TEST_CNT   = 4'd3;
  localparam logic [3:0] S_TEST_CHK   = 4'd4;
  localparam logic [3:0] S_TEST_WALK  = 4'd5;
  localparam logic [3:0] S_TEST_DRAIN = 4'd6;
  localparam logic [3:0] S_DONE       = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.action)
          pcpf_pkg::ACT_BEGIN: begin
            cmd.set_status = 1'b1;
            if (sts.cid_ok) begin
              cmd.cnt_wr  = 1'b1;
              cmd.cnt_clr = 1'b1;
              cmd.status  = pcpf_pkg::ST_ACCEPTED;
            end else begin
              cmd.status  = pcpf_pkg::ST_DROPPED;
            end
            state_next = S_DONE;
          end
          pcpf_pkg::ACT_APPEND: begin
            if (sts.cid_ok) begin
              cmd.cnt_rd = 1'b1;
              state_next = S_LOAD_WR;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = pcpf_pkg::ST_DROPPED;
              state_next     = S_DONE;
            end
          end
          pcpf_pkg::ACT_TEST: begin
            cmd.walk_init = 1'b1;
            state_next    = S_TEST_CNT;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = pcpf_pkg::ST_DROPPED;
            state_next     = S_DONE;
          end
        endcase
      end
      S_LOAD_WR: begin
        cmd.set_status = 1'b1;
        if (sts.room) begin
          cmd.store_wr = 1'b1;
          cmd.cnt_wr   = 1'b1;
          cmd.status   = pcpf_pkg::ST_ACCEPTED;
        end else begin
          cmd.status   = pcpf_pkg::ST_DROPPED;
        end
        state_next = S_DONE;
      end
      S_TEST_CNT: begin
        cmd.cnt_rd   = 1'b1;
        cmd.cnt_walk = 1'b1;
        state_next   = S_TEST_CHK;
      end
      S_TEST_CHK: begin
        if (!sts.cnt_zero) begin
          cmd.pt_start = 1'b1;
          state_next   = S_TEST_WALK;
        end else if (sts.clu_last) begin
          state_next   = S_TEST_DRAIN;
        end else begin
          cmd.clu_next = 1'b1;
          state_next   = S_TEST_CNT;
        end
      end
      S_TEST_WALK: begin
        cmd.pt_rd = 1'b1;
        if (sts.pt_last) begin
          if (sts.clu_last) begin
            state_next   = S_TEST_DRAIN;
          end else begin
            cmd.clu_next = 1'b1;
            state_next   = S_TEST_CNT;
          end
        end
      end
      S_TEST_DRAIN: begin
        // wait for the distance pipeline to empty
        if (!sts.busy) begin
          cmd.set_status = 1'b1;
          cmd.status     = sts.hit ? pcpf_pkg::ST_REMOVED : pcpf_pkg::ST_KEPT;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_push = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/pcpf_dp.sv @@
// ----------------------------------------------------------------------------
// pcpf_dp
// Datapath: point store, cluster counts, walk counters, squared distance
// pipeline, limit register and output register.
// ----------------------------------------------------------------------------
module pcpf_dp #(
  parameter int MAX_CLUSTERS       = 32,
  parameter int POINTS_PER_CLUSTER = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [15:0]     cfg_data,
  input  pcpf_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pcpf_pkg::rsp_t  rsp_data,
  input  pcpf_pkg::cmd_t  cmd,
  output pcpf_pkg::sts_t  sts
);

  localparam int DEPTH = MAX_CLUSTERS * POINTS_PER_CLUSTER;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW    = (POINTS_PER_CLUSTER > 1) ? $clog2(POINTS_PER_CLUSTER) : 1;
  localparam int CW    = $clog2(POINTS_PER_CLUSTER + 1);
  localparam logic [AW-1:0]  PPC_A    = AW'(POINTS_PER_CLUSTER);
  localparam logic [CW-1:0]  PPC_C    = CW'(POINTS_PER_CLUSTER);
  localparam logic [CIW-1:0] LAST_CLU = CIW'(MAX_CLUSTERS - 1);
  localparam logic [8:0]     MAX_C9   = 9'(MAX_CLUSTERS);

  // request and limit
  pcpf_pkg::req_t item;
  logic [15:0]    dist_limit;
  logic [31:0]    lim_sq;
  logic [1:0]     res_status;

  logic [CIW-1:0] cid_idx;

  // cluster counts with valid bits
  logic [CW-1:0]  cnt_mem [MAX_CLUSTERS];
  logic           cnt_vld [MAX_CLUSTERS];
  logic [CW-1:0]  cnt_q;
  logic [CIW-1:0] cnt_addr;

  // point store
  logic [47:0]    store_mem [DEPTH];
  logic [47:0]    st_q;
  logic [AW-1:0]  ld_addr;
  logic [AW-1:0]  rd_addr;

  // walk counters
  logic [CIW-1:0] clu;
  logic [AW-1:0]  base;
  logic [KW-1:0]  k;

  // distance pipeline
  logic               v1;
  logic               v2;
  logic               hit;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] dz;
  logic [15:0]        ax;
  logic [15:0]        ay;
  logic [15:0]        az;
  logic [31:0]        sqx;
  logic [31:0]        sqy;
  logic [31:0]        sqz;
  logic [33:0]        d2;

  assign cid_idx = CIW'(item.slot);
  assign cnt_addr = cmd.cnt_walk ? clu : cid_idx;
  assign ld_addr  = AW'(AW'(cid_idx) * PPC_A) + AW'(cnt_q);
  assign rd_addr  = base + AW'(k);

  // status
  assign sts.action   = item.action;
  assign sts.cid_ok   = (9'(item.slot) < MAX_C9);
  assign sts.room     = (cnt_q < PPC_C);
  assign sts.cnt_zero = (cnt_q == '0);
  assign sts.pt_last  = ((CW'(k) + CW'(1)) == cnt_q);
  assign sts.clu_last = (clu == LAST_CLU);
  assign sts.busy     = v1 | v2;
  assign sts.hit      = hit;
  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_limit <= pcpf_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      dist_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    lim_sq <= dist_limit * dist_limit;
    if (cmd.take) begin
      item <= req_data;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
  end

  // cluster count memory; entries never written read as zero
  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) begin
      cnt_q <= cnt_vld[cnt_addr] ? cnt_mem[cnt_addr] : '0;
    end
    if (cmd.cnt_wr) begin
      cnt_mem[cid_idx] <= cmd.cnt_clr ? '0 : cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_vld[i] <= 1'b0;
      end
    end else if (cmd.cnt_wr) begin
      cnt_vld[cid_idx] <= 1'b1;
    end
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      store_mem[ld_addr] <= {item.x, item.y, item.z};
    end
    if (cmd.pt_rd) begin
      st_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      clu  <= '0;
      base <= '0;
    end else if (cmd.clu_next) begin
      clu  <= clu + CIW'(1);
      base <= base + PPC_A;
    end
    if (cmd.pt_start) begin
      k <= '0;
    end else if (cmd.pt_rd) begin
      k <= k + KW'(1);
    end
  end

  // stage 1: absolute differences and squares
  always_comb begin
    dx = {item.x[15], item.x} - {st_q[47], st_q[47:32]};
    dy = {item.y[15], item.y} - {st_q[31], st_q[31:16]};
    dz = {item.z[15], item.z} - {st_q[15], st_q[15:0]};
    ax = dx[16] ? 16'(-dx) : dx[15:0];
    ay = dy[16] ? 16'(-dy) : dy[15:0];
    az = dz[16] ? 16'(-dz) : dz[15:0];
  end

  always_ff @(posedge clk) begin
    sqx <= ax * ax;
    sqy <= ay * ay;
    sqz <= az * az;
  end

  // stage 2: sum and strict compare against limit squared
  assign d2 = 34'(sqx) + 34'(sqy) + 34'(sqz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1 <= cmd.pt_rd;
      v2 <= v1;
      if (cmd.walk_init) begin
        hit <= 1'b0;
      end else if (v2 && (d2 < 34'(lim_sq))) begin
        hit <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_push) begin
      rsp_data.status <= res_status;
      rsp_data.out_x  <= item.x;
      rsp_data.out_y  <= item.y;
      rsp_data.out_z  <= item.z;
    end
  end

endmodule

@@ hdl/point_cluster_proximity_filter.sv @@
// ----------------------------------------------------------------------------
// point_cluster_proximity_filter
// Stores clusters of 3D points and removes query points that fall within
// the exclusion radius of any stored point.
// ----------------------------------------------------------------------------
//  channel  signals                        payload
//  req      req_valid, req_stall (in)      req_data  : pcpf_pkg::req_t
//  rsp      rsp_valid, rsp_stall (out)     rsp_data  : pcpf_pkg::rsp_t
//  cfg      cfg_valid, cfg_ready           cfg_data  : distance_limit, 16 bit
//
//  Begin, out-of-range and unused-action requests go from decode straight to
//  the result; an append first reads the cluster count, then writes the point.
//  A test looks up the count of every cluster in turn, issues one store read
//  per stored point, then waits for the distance pipeline to drain.
//  Reset clears the cluster counts (valid bits), the limit (128) and control.
//  A new request is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
module point_cluster_proximity_filter #(
  parameter int MAX_CLUSTERS       = 32,
  parameter int POINTS_PER_CLUSTER = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pcpf_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pcpf_pkg::rsp_t  rsp_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data
);

  pcpf_pkg::cmd_t cmd;
  pcpf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pcpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcpf_dp #(
    .MAX_CLUSTERS       (MAX_CLUSTERS),
    .POINTS_PER_CLUSTER (POINTS_PER_CLUSTER)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
